// File: hw/rtl/crrp_pkg.sv
// crrp_pkg: shared types, codes and defaults for the cooldown round-robin picker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package crrp_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int Q_DEPTH = 2;
    localparam logic [31:0] WAIT_LIMIT_RESET = 32'd60;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_PICK    = 2'd1,
        OP_MARK    = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_NONE  = 3'd2;
    localparam logic [2:0] ST_DUP   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    localparam logic [2:0] ST_NOKEY = 3'd5;

    typedef struct packed {
        op_t         op;
        logic        key_empty;
        logic [15:0] key;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic {
        BK_LOAD = 1'b0,
        BK_EXEC = 1'b1
    } bk_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/crrp_front.sv
// crrp_front: input stage, takes items and classifies them into commands
// depends on crrp_pkg; feeds crrp_queue
`timescale 1ns / 1ps
`default_nettype none

module crrp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     opcode,
    input  wire logic [15:0]    server_key,
    input  wire logic [31:0]    now,
    input  wire crrp_pkg::q_stat_t q_stat,
    output logic                q_push,
    output crrp_pkg::cmd_t      q_cmd
);
    import crrp_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    logic accept;

    assign in_ready = !hold_valid_reg || !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign q_push   = hold_valid_reg && !q_stat.full;
    assign q_cmd    = hold_cmd_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg.op        <= op_t'(opcode);
            hold_cmd_reg.key_empty <= (server_key == 16'd0);
            hold_cmd_reg.key       <= server_key;
            hold_cmd_reg.now       <= now;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/crrp_queue.sv
// crrp_queue: short command queue between front and back
// depends on crrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module crrp_queue #(
    parameter int DEPTH = crrp_pkg::Q_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire crrp_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output crrp_pkg::cmd_t      head_cmd,
    output crrp_pkg::q_stat_t   stat
);
    import crrp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    assign stat.full  = (fill_reg == CNT_W'(DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/crrp_back.sv
// crrp_back: server ring cells, two-step execution and result register
// depends on crrp_pkg; takes commands from crrp_queue
`timescale 1ns / 1ps
`default_nettype none

module crrp_back #(
    parameter int ENTRIES = crrp_pkg::DEF_ENTRIES
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire crrp_pkg::q_stat_t q_stat,
    input  wire crrp_pkg::cmd_t head_cmd,
    output logic                q_pop,
    input  wire logic [31:0]    wait_limit,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [2:0]          status,
    output logic [15:0]         picked_key
);
    import crrp_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [15:0]      key_reg    [ENTRIES];
    logic [15:0]      key_next   [ENTRIES];
    logic [31:0]      stamp_reg  [ENTRIES];
    logic [31:0]      stamp_next [ENTRIES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] cursor_reg;
    logic [IDX_W-1:0] cursor_next;

    bk_state_t        state_reg;
    bk_state_t        state_next;
    cmd_t             cmd_reg;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_next;
    logic [ENTRIES-1:0] elig_reg;
    logic [ENTRIES-1:0] elig_next;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] cur_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [2:0]       status_reg;
    logic [2:0]       status_next;
    logic [15:0]      picked_reg;
    logic [15:0]      picked_next;

    logic             fire;
    logic [ENTRIES-1:0] hi_mask;
    logic [ENTRIES-1:0] src_mask;
    logic [ENTRIES-1:0] first_hot;
    logic [IDX_W-1:0] pick_idx;
    logic [15:0]      pick_key;
    logic [CNT_W-1:0] pick_inc;
    logic             any_match;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign picked_key = picked_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_LOAD:
            begin
                if (!q_stat.empty)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_LOAD;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop = 1'b0;
        fire  = 1'b0;
        unique case (state_reg)
            BK_LOAD:
            begin
                q_pop = !q_stat.empty;
            end
            BK_EXEC:
            begin
                fire = !out_valid_reg || out_ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // per-cell compare against the queue head
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = (CNT_W'(i) < count_reg) && (key_reg[i] == head_cmd.key);
            elig_next[i]  = (CNT_W'(i) < count_reg)
                            && ((head_cmd.now - stamp_reg[i]) > wait_limit);
        end
        cur_next = (CNT_W'(cursor_reg) < count_reg) ? cursor_reg : '0;
    end

    // find first eligible cell from the cursor around the ring
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hi_mask[i] = elig_reg[i] && (IDX_W'(i) >= cur_reg);
        end
        src_mask  = (|hi_mask) ? hi_mask : elig_reg;
        first_hot = src_mask & (~src_mask + ENTRIES'(1));
        pick_idx  = '0;
        pick_key  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (first_hot[i])
            begin
                pick_idx = pick_idx | IDX_W'(i);
                pick_key = pick_key | key_reg[i];
            end
        end
        pick_inc  = CNT_W'(pick_idx) + CNT_W'(1);
        any_match = |match_reg;
    end

    // execution
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_next[i]   = key_reg[i];
            stamp_next[i] = stamp_reg[i];
        end
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        status_next    = status_reg;
        picked_next    = picked_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            picked_next    = '0;
            if (cmd_reg.op == OP_ADD)
            begin
                if (cmd_reg.key_empty)
                begin
                    status_next = ST_NOKEY;
                end
                else if (any_match)
                begin
                    status_next = ST_DUP;
                end
                else if (count_reg == CNT_W'(ENTRIES))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    for (int i = 1; i < ENTRIES; i++)
                    begin
                        if ((IDX_W'(i) > cur_reg) && (CNT_W'(i) <= count_reg))
                        begin
                            key_next[i]   = key_reg[i-1];
                            stamp_next[i] = stamp_reg[i-1];
                        end
                    end
                    key_next[cur_reg]   = cmd_reg.key;
                    stamp_next[cur_reg] = '0;
                    count_next          = count_reg + CNT_W'(1);
                    cursor_next         = cur_reg;
                end
            end
            else if (count_reg == '0)
            begin
                status_next = ST_EMPTY;
            end
            else if (cmd_reg.op == OP_PICK)
            begin
                if (|elig_reg)
                begin
                    stamp_next[pick_idx] = cmd_reg.now;
                    picked_next          = pick_key;
                    cursor_next = (pick_inc >= count_reg) ? '0 : pick_inc[IDX_W-1:0];
                end
                else
                begin
                    status_next = ST_NONE;
                end
            end
            else if (any_match)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (match_reg[i])
                    begin
                        stamp_next[i] = (cmd_reg.op == OP_MARK) ? cmd_reg.now : 32'd0;
                    end
                end
            end
            else
            begin
                status_next = ST_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_LOAD;
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i]   <= key_next[i];
            stamp_reg[i] <= stamp_next[i];
        end
        status_reg <= status_next;
        picked_reg <= picked_next;
        if (q_pop)
        begin
            cmd_reg   <= head_cmd;
            match_reg <= match_next;
            elig_reg  <= elig_next;
            cur_reg   <= cur_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cooldown_round_robin_picker_unit.sv
// cooldown_round_robin_picker_unit: top level of the cooldown round-robin picker
// depends on crrp_pkg, crrp_front, crrp_queue, crrp_back
//
// Keeps a ring of up to ENTRIES servers, each a 16-bit key with a 32-bit last-use stamp,
// and answers add, pick, mark-used and release with one result item each. An item is
// registered by the front stage, waits in a two-entry queue and is then run by the back
// stage in a load step and an execute step: the load step pops the command and compares
// every ring cell against it (key match and age above wait_limit), the execute step finds
// the first hit from the cursor, updates the ring and loads the result register. The back
// stage takes a new item from the queue only once the last one has executed, and execution
// waits while an unaccepted result is held. wait_limit resets to 60; the user must write
// it only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module cooldown_round_robin_picker_unit #(
    parameter int ENTRIES = crrp_pkg::DEF_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] server_key,
    input  wire logic [31:0] now,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      picked_key,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);
    import crrp_pkg::*;

    logic [31:0] wait_limit_reg;
    logic [31:0] wait_limit_next;
    logic        q_push;
    logic        q_pop;
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    q_stat_t     q_stat;

    assign wait_limit_next = cfg_we ? cfg_wdata : wait_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_limit_reg <= WAIT_LIMIT_RESET;
        end
        else
        begin
            wait_limit_reg <= wait_limit_next;
        end
    end

    crrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .server_key (server_key),
        .now        (now),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    crrp_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    crrp_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head_cmd   (head_cmd),
        .q_pop      (q_pop),
        .wait_limit (wait_limit_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .picked_key (picked_key)
    );

endmodule

`default_nettype wire

// File: hw/rtl/crrp_checker.sv
// crrp_checker: port-level assertions for the cooldown round-robin picker
// depends on crrp_pkg; bound to cooldown_round_robin_picker_unit
`timescale 1ns / 1ps
`default_nettype none

module crrp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [2:0]  status,
    input  wire logic [15:0] picked_key
);
    import crrp_pkg::*;

    // items accepted but not yet delivered
    logic [3:0] pending_reg;
    logic [3:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            pending_next = pending_reg + 4'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(picked_key))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result without an accepted item");

    a_fail_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> picked_key == 16'd0)
        else $error("picked key set on a failed item");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_NOKEY)
        else $error("status code out of range");

endmodule

bind cooldown_round_robin_picker_unit crrp_checker u_chk (.*);

`default_nettype wire
